FILE: hw/rtl/pas_pkg.sv
// Package with shared types and constants for the positional array store.
package pas_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned ActW   = 3;
  localparam int unsigned TotalW = 38;
  localparam int unsigned StatW  = 2;

  typedef enum logic [2:0] {
    ActRead    = 3'd0,
    ActInsert  = 3'd1,
    ActRemove  = 3'd2,
    ActSortAsc = 3'd3,
    ActSortDsc = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StIndex = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SMove,
    SSortRd,
    SSortWr,
    SScanRd,
    SScan,
    SDone
  } state_e;

  // Request for the shared compare unit: sort direction and the two operands.
  typedef struct packed {
    logic               ascending;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic swap;   // a and b are out of order
    logic a_less; // a < b
  } cmp_rsp_t;

endpackage

FILE: hw/rtl/pas_cmp.sv
// Shared signed compare unit used by the sort and the minimum scan.
module pas_cmp (
  input  pas_pkg::cmp_req_t req_i,
  output pas_pkg::cmp_rsp_t rsp_o
);
  always_comb begin
    rsp_o.a_less = req_i.a < req_i.b;
    rsp_o.swap   = req_i.ascending ? (req_i.a > req_i.b) : (req_i.a < req_i.b);
  end
endmodule

FILE: hw/rtl/positional_array_store_unit.sv
// Top level of the positional array store: sequencer, entry memory and result register.
//
//  channel | direction | signals
//  --------+-----------+-------------------------------------------------------
//  in      | input     | in_valid_i, in_ready_o, action_i, position_i, new_value_i
//  out     | output    | out_valid_o, out_ready_i, read_value_o, entry_count_o,
//          |           | smallest_o, smallest_valid_o, total_o, status_o
//
// One word is handled at a time; in_ready_o is high only in the idle state.
// Every word ends with a scan that rebuilds the minimum and the sum from the held
// entries through one memory read port and the shared compare unit; a read first
// fetches its entry and a rejected word goes straight to the scan. An insert or
// remove first moves entries one at a time, each read in SMove and written back in
// SSortWr, then an insert writes its value into the freed slot and a remove drops
// the count. A sort is an insertion sort that shifts one entry per cycle.
// Reset clears the count and control; the memory holds no reset value.
// The result word waits in its own register while out_ready_i is low; a new word
// can start meanwhile and stalls at the end of its scan until that register frees.
module positional_array_store_unit #(
  parameter int unsigned DEPTH = pas_pkg::DepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pas_pkg::ActW-1:0]          action_i,
  input  logic [pas_pkg::PosW-1:0]          position_i,
  input  logic signed [pas_pkg::DataW-1:0]  new_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pas_pkg::DataW-1:0]  read_value_o,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count_o,
  output logic signed [pas_pkg::DataW-1:0]  smallest_o,
  output logic                              smallest_valid_o,
  output logic signed [pas_pkg::TotalW-1:0] total_o,
  output logic [pas_pkg::StatW-1:0]         status_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);
  localparam int unsigned PW = (CW > pas_pkg::PosW) ? CW : pas_pkg::PosW;

  logic signed [pas_pkg::DataW-1:0] mem_q [DEPTH];
  logic signed [pas_pkg::DataW-1:0] rdata_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic signed [pas_pkg::DataW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  pas_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [pas_pkg::ActW-1:0] act_q, act_d;
  logic [CW-1:0] pos_q, pos_d;
  logic signed [pas_pkg::DataW-1:0] val_q, val_d;
  logic [CW-1:0] i_q, i_d;   // outer index / move index / scan index
  logic [CW-1:0] j_q, j_d;   // insertion slot
  logic signed [pas_pkg::DataW-1:0] key_q, key_d;
  logic signed [pas_pkg::DataW-1:0] rd_q, rd_d;
  logic [pas_pkg::StatW-1:0] st_q, st_d;
  logic signed [pas_pkg::DataW-1:0] min_q, min_d;
  logic signed [pas_pkg::TotalW-1:0] sum_q, sum_d;
  logic out_v_q, out_v_d;

  // Result register, loaded when a scan completes or an empty store finishes.
  logic out_load;
  logic out_free;
  logic signed [pas_pkg::DataW-1:0] out_rd_q;
  logic [CW-1:0] out_cnt_q;
  logic signed [pas_pkg::DataW-1:0] out_min_q;
  logic signed [pas_pkg::TotalW-1:0] out_sum_q;
  logic [pas_pkg::StatW-1:0] out_st_q;

  pas_pkg::cmp_req_t creq;
  pas_pkg::cmp_rsp_t crsp;
  pas_cmp u_cmp (.req_i(creq), .rsp_o(crsp));

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  assign pos_ext = PW'(position_i);
  assign cnt_ext = PW'(cnt_q);
  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pas_pkg::SIdle;
      cnt_q     <= '0;
      out_v_q   <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
      if (out_load) out_cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; pos_q <= pos_d; val_q <= val_d;
    i_q <= i_d; j_q <= j_d; key_q <= key_d;
    rd_q <= rd_d; st_q <= st_d; min_q <= min_d; sum_q <= sum_d;
    if (out_load) begin
      out_rd_q  <= rd_d;
      out_min_q <= min_d;
      out_sum_q <= sum_d;
      out_st_q  <= st_d;
    end
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; act_d = act_q; pos_d = pos_q; val_d = val_q;
    i_d = i_q; j_d = j_q; key_d = key_q; rd_d = rd_q; st_d = st_q;
    min_d = min_q; sum_d = sum_q; out_v_d = out_v_q; out_load = 1'b0;
    raddr = i_q[AW-1:0];
    we = 1'b0; waddr = j_q[AW-1:0]; wdata = key_q;
    creq.ascending = act_q == pas_pkg::ActSortAsc;
    creq.a = rdata_q; creq.b = key_q;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    case (state_q)
      pas_pkg::SIdle: begin
        if (in_valid_i) begin
          act_d = action_i; pos_d = CW'(pos_ext); val_d = new_value_i;
          rd_d = '0; st_d = pas_pkg::StOk; state_d = pas_pkg::SScanRd;
          i_d = '0;
          case (action_i)
            pas_pkg::ActRead: begin
              if (pos_ext >= cnt_ext) st_d = pas_pkg::StIndex;
              else begin raddr = AW'(pos_ext); state_d = pas_pkg::SDone; end
            end
            pas_pkg::ActInsert: begin
              if (pos_ext > cnt_ext) st_d = pas_pkg::StIndex;
              else if (cnt_q == CW'(DEPTH)) st_d = pas_pkg::StFull;
              else begin i_d = cnt_q; state_d = pas_pkg::SMove; end
            end
            pas_pkg::ActRemove: begin
              if (pos_ext >= cnt_ext) st_d = pas_pkg::StIndex;
              else begin i_d = CW'(pos_ext); state_d = pas_pkg::SMove; end
            end
            pas_pkg::ActSortAsc, pas_pkg::ActSortDsc: begin
              if (cnt_q > CW'(1)) begin i_d = CW'(1); state_d = pas_pkg::SSortRd; end
            end
            default: ;
          endcase
          raddr = (state_d == pas_pkg::SDone) ? AW'(pos_ext) : i_d[AW-1:0];
        end
      end
      // SDone entered from a read: rdata holds the entry, then scan.
      pas_pkg::SDone: begin
        rd_d = rdata_q; i_d = '0; raddr = '0; state_d = pas_pkg::SScan;
        sum_d = '0; min_d = '0;
        if (cnt_q == '0) state_d = pas_pkg::SScanRd;
      end
      // Entries move one at a time: SMove reads each one and SSortWr writes it back.
      pas_pkg::SMove: begin
        if (act_q == pas_pkg::ActInsert) begin
          if (i_q == pos_q) begin
            we = 1'b1; waddr = i_q[AW-1:0]; wdata = val_q;
            cnt_d = cnt_q + CW'(1); i_d = '0; state_d = pas_pkg::SScanRd;
          end else begin
            raddr = AW'(i_q - CW'(1));
            state_d = pas_pkg::SSortWr; // reused as move-write cycle
          end
        end else begin
          if (i_q + CW'(1) >= cnt_q) begin
            cnt_d = cnt_q - CW'(1); i_d = '0; state_d = pas_pkg::SScanRd;
          end else begin
            raddr = AW'(i_q + CW'(1)); state_d = pas_pkg::SSortWr;
          end
        end
      end
      pas_pkg::SSortRd: begin
        // Fetch key at i.
        raddr = i_q[AW-1:0]; j_d = i_q; state_d = pas_pkg::SSortWr;
        key_d = '0; act_d = act_q;
        if (i_q >= cnt_q) begin i_d = '0; state_d = pas_pkg::SScanRd; end
        else pos_d = '1; // marks key load pending
      end
      pas_pkg::SSortWr: begin
        if (act_q == pas_pkg::ActInsert) begin
          we = 1'b1; waddr = i_q[AW-1:0]; wdata = rdata_q;
          i_d = i_q - CW'(1); state_d = pas_pkg::SMove;
        end else if (act_q == pas_pkg::ActRemove) begin
          we = 1'b1; waddr = i_q[AW-1:0]; wdata = rdata_q;
          i_d = i_q + CW'(1); state_d = pas_pkg::SMove;
        end else if (pos_q == '1) begin
          key_d = rdata_q; pos_d = '0;
          raddr = AW'(j_q - CW'(1));
        end else begin
          // rdata = entry[j-1]; compare against key.
          if (crsp.swap) begin
            we = 1'b1; waddr = j_q[AW-1:0]; wdata = rdata_q;
            j_d = j_q - CW'(1);
            if (j_q == CW'(1)) begin
              // slot 0 next cycle; write key there via the no-move path
              pos_d = '0; raddr = '0; state_d = pas_pkg::SMove;
              act_d = act_q; i_d = i_q;
            end else raddr = AW'(j_q - CW'(2));
          end else begin
            we = 1'b1; waddr = j_q[AW-1:0]; wdata = key_q;
            i_d = i_q + CW'(1); state_d = pas_pkg::SSortRd;
          end
        end
      end
      pas_pkg::SScanRd: begin
        raddr = '0; i_d = '0; sum_d = '0; min_d = '0;
        state_d = pas_pkg::SScan;
        if (cnt_q == '0) begin
          // An empty store finishes here once the result register is free.
          state_d = pas_pkg::SScanRd;
          if (out_free) begin
            out_v_d = 1'b1; out_load = 1'b1; state_d = pas_pkg::SIdle;
          end
        end
        if (act_q == pas_pkg::ActSortAsc || act_q == pas_pkg::ActSortDsc) begin
          // Sort reached SMove only to place key at slot 0.
        end
      end
      pas_pkg::SScan: begin
        // The last entry waits, rereading its address, while the result register is full.
        if (i_q + CW'(1) < cnt_q || out_free) begin
          creq.a = rdata_q; creq.b = min_q;
          sum_d = sum_q + pas_pkg::TotalW'(rdata_q);
          if (i_q == '0 || crsp.a_less) min_d = rdata_q;
          raddr = AW'(i_q + CW'(1));
          i_d = i_q + CW'(1);
          if (i_q + CW'(1) >= cnt_q) begin
            out_v_d = 1'b1; out_load = 1'b1; state_d = pas_pkg::SIdle;
          end
        end
      end
      default: state_d = pas_pkg::SIdle;
    endcase
    // Sort placing key at slot 0 after the last shift.
    if (state_q == pas_pkg::SMove &&
        (act_q == pas_pkg::ActSortAsc || act_q == pas_pkg::ActSortDsc)) begin
      we = 1'b1; waddr = '0; wdata = key_q; cnt_d = cnt_q;
      i_d = i_q + CW'(1); state_d = pas_pkg::SSortRd; raddr = i_q[AW-1:0];
    end
  end

  assign in_ready_o       = state_q == pas_pkg::SIdle;
  assign out_valid_o      = out_v_q;
  assign read_value_o     = out_rd_q;
  assign entry_count_o    = out_cnt_q;
  assign smallest_o       = out_min_q;
  assign smallest_valid_o = out_cnt_q != '0;
  assign total_o          = out_sum_q;
  assign status_o         = out_st_q;
endmodule

FILE: hw/rtl/pas_checker.sv
// Port checker for the positional array store, bound to the top level.
module pas_checker #(
  parameter int unsigned DEPTH = pas_pkg::DepthDefault
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [$clog2(DEPTH+1)-1:0] entry_count_o,
  input logic smallest_valid_o,
  input logic [pas_pkg::StatW-1:0] status_o
);
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready right after accept");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o <= ($clog2(DEPTH+1))'(DEPTH)) else $error("count above depth");
  a_min_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (smallest_valid_o == (entry_count_o != '0)))
    else $error("min valid mismatch");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == pas_pkg::StOk || status_o == pas_pkg::StIndex ||
                     status_o == pas_pkg::StFull)) else $error("bad status");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
endmodule

bind positional_array_store_unit pas_checker #(.DEPTH(DEPTH)) u_pas_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .entry_count_o(entry_count_o), .smallest_valid_o(smallest_valid_o),
  .status_o(status_o)
);

FILE: test/positional_array_store_unit_test.sv
// Self-checking testbench for the positional array store top level.
module positional_array_store_unit_test;

  localparam int unsigned Depth = 64;

  // Scoreboard: tracks the expected store contents and queues the expected result words.
  class store_scoreboard;
    typedef struct packed {
      logic signed [31:0] rd;
      logic [6:0]         cnt;
      logic signed [31:0] least;
      logic               least_ok;
      logic signed [37:0] sum;
      logic [1:0]         st;
    } result_t;

    logic signed [31:0] cells[Depth];
    int unsigned        held;
    result_t            pending[$];
    int                 errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function void order_cells(bit ascending);
      logic signed [31:0] key;
      int j;
      for (int i = 1; i < held; i++) begin
        key = cells[i];
        j = i;
        while (j > 0 && (ascending ? cells[j-1] > key : cells[j-1] < key)) begin
          cells[j] = cells[j-1];
          j--;
        end
        cells[j] = key;
      end
    endfunction

    function void note_word(logic [2:0] act, logic [5:0] pos, logic signed [31:0] val);
      result_t r;
      r = '0;
      case (act)
        pas_pkg::ActRead: begin
          if (pos < held) r.rd = cells[pos];
          else r.st = pas_pkg::StIndex;
        end
        pas_pkg::ActInsert: begin
          if (pos > held) r.st = pas_pkg::StIndex;
          else if (held >= Depth) r.st = pas_pkg::StFull;
          else begin
            for (int i = held; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = val;
            held++;
          end
        end
        pas_pkg::ActRemove: begin
          if (pos >= held) r.st = pas_pkg::StIndex;
          else begin
            for (int i = pos; i + 1 < held; i++) cells[i] = cells[i+1];
            held--;
          end
        end
        pas_pkg::ActSortAsc: order_cells(1'b1);
        pas_pkg::ActSortDsc: order_cells(1'b0);
        default: ;
      endcase
      for (int i = 0; i < held; i++) begin
        r.sum += 38'(cells[i]);
        if (i == 0 || cells[i] < r.least) r.least = cells[i];
      end
      r.cnt = 7'(held);
      r.least_ok = held > 0;
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endtask

    task check_word(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing expected", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (got.rd != e.rd) report_mismatch("read_value", got.rd, e.rd);
      if (got.cnt != e.cnt) report_mismatch("entry_count", got.cnt, e.cnt);
      if (got.least != e.least) report_mismatch("smallest", got.least, e.least);
      if (got.least_ok != e.least_ok)
        report_mismatch("smallest_valid", got.least_ok, e.least_ok);
      if (got.sum != e.sum) report_mismatch("total", got.sum, e.sum);
      if (got.st != e.st) report_mismatch("status", got.st, e.st);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] action_i = '0;
  logic [5:0] position_i = '0;
  logic signed [31:0] new_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] read_value_o;
  logic [6:0] entry_count_o;
  logic signed [31:0] smallest_o;
  logic smallest_valid_o;
  logic signed [37:0] total_o;
  logic [1:0] status_o;

  store_scoreboard board = new();
  bit calm_tail = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  positional_array_store_unit #(.DEPTH(Depth)) dut (.*);

  // Result side: stalls in random bursts, checks each accepted word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_word({read_value_o, entry_count_o, smallest_o,
                        smallest_valid_o, total_o, status_o});
  end

  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 13);
        out_ready_i <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Sends one word, holding it until accepted; idles first at random.
  task automatic send_word(logic [2:0] act, logic [5:0] pos, logic signed [31:0] val);
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    position_i <= pos;
    new_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(act, pos, val);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Index that is usually below the given span, sometimes any 6-bit value.
  function automatic logic [5:0] pick_pos(int unsigned span);
    if ($urandom_range(0, 9) == 0) return 6'($urandom);
    if (span == 0) return 6'd0;
    return 6'($urandom_range(0, span - 1));
  endfunction

  task automatic random_word();
    int unsigned h;
    int unsigned roll;
    h = board.held;
    roll = $urandom_range(0, 99);
    // Keep the count drifting across the whole range, with sorts now and then.
    if (roll < 40) send_word(pas_pkg::ActInsert, pick_pos(h + 1), pick_value());
    else if (roll < 65) send_word(pas_pkg::ActRead, pick_pos(h), pick_value());
    else if (roll < 88) send_word(pas_pkg::ActRemove, pick_pos(h), pick_value());
    else if (roll < 93) send_word(pas_pkg::ActSortAsc, 6'($urandom), $urandom);
    else if (roll < 97) send_word(pas_pkg::ActSortDsc, 6'($urandom), $urandom);
    else send_word(3'($urandom_range(5, 7)), 6'($urandom), $urandom);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty store cases, extremes, unknown action, fill to full.
    send_word(pas_pkg::ActRead, 6'd0, 32'sd0);
    send_word(pas_pkg::ActRemove, 6'd0, 32'sd0);
    send_word(pas_pkg::ActSortAsc, 6'd0, 32'sd0);
    send_word(pas_pkg::ActInsert, 6'd1, 32'sd5);
    send_word(pas_pkg::ActInsert, 6'd0, 32'sh7fffffff);
    send_word(pas_pkg::ActSortDsc, 6'd0, 32'sd0);
    send_word(pas_pkg::ActInsert, 6'd0, 32'sh80000000);
    send_word(pas_pkg::ActInsert, 6'd2, -32'sd1);
    send_word(pas_pkg::ActRead, 6'd2, 32'sd0);
    send_word(pas_pkg::ActRead, 6'd3, 32'sd0);
    send_word(pas_pkg::ActSortAsc, 6'd63, 32'sd0);
    send_word(pas_pkg::ActSortDsc, 6'd0, 32'sd0);
    send_word(3'd5, 6'd0, 32'sd0);
    send_word(3'd7, 6'd63, 32'hffffffff);
    send_word(pas_pkg::ActRemove, 6'd1, 32'sd0);
    while (board.held < Depth)
      send_word(pas_pkg::ActInsert, 6'(board.held), 32'sh7fffffff);
    send_word(pas_pkg::ActInsert, 6'd0, 32'sd1);
    send_word(pas_pkg::ActInsert, 6'd63, 32'sd0);
    send_word(pas_pkg::ActRead, 6'd63, 32'sd0);
    send_word(pas_pkg::ActRemove, 6'd63, 32'sd0);
    send_word(pas_pkg::ActInsert, 6'd63, 32'sh80000000);
    send_word(pas_pkg::ActSortDsc, 6'd0, 32'sd0);
    send_word(pas_pkg::ActSortAsc, 6'd0, 32'sd0);
    for (int n = 0; n < 1400; n++) begin
      if (n == 1250) calm_tail = 1'b1;
      random_word();
    end
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Worst case: sorts of 64 entries, plus stalls, for every word.
  initial begin
    #100000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
